@@ rtl/agrs_pkg.sv @@
// Shared types, constants and lookup functions for the angle relation score block.
// Used by every module under rtl; depends on nothing.
package agrs_pkg;

    typedef enum logic [0:0] {
        OP_QUERY = 1'b0,
        OP_LOAD  = 1'b1
    } op_t;

    // Classes whose target anchor sits at a fixed fraction of the box height.
    localparam logic [4:0] CLS_PCT10_A = 5'd3;
    localparam logic [4:0] CLS_PCT10_B = 5'd8;
    localparam logic [4:0] CLS_PCT25   = 5'd9;
    localparam logic [4:0] CLS_PCT05   = 5'd5;
    localparam logic [4:0] CLS_PCT33   = 5'd7;

    localparam int CORDIC_W  = 46;
    localparam int ANGLE_W   = 21;
    localparam int DELTA_W   = 27;
    localparam int CORDIC_N  = 16;

    localparam logic signed [ANGLE_W-1:0] PI_Q16     = 21'sd205887;
    localparam logic signed [18:0]        TWO_PI_Q12 = 19'sd25736;
    localparam logic [33:0]               U_LIMIT    = 34'd5242880;
    localparam logic [63:0]               EXP_EIGHTH = 64'd947573834;
    localparam logic [28:0]               PEAK_Q30   = 29'd428361012;
    localparam logic [31:0]               Q30_ONE    = 32'd1073741824;
    // Reciprocals for exact floor division of the Taylor terms.
    localparam logic [21:0]               RECIP_6    = 22'd2796203;
    localparam logic [18:0]               RECIP_24   = 19'd349526;

    typedef struct packed {
        logic               no_data;
        logic               zero;
        logic signed [15:0] ref_ang;
        logic [15:0]        inv;
    } side_t;

    typedef logic [127:0][30:0] cm_tab_t;

    function automatic logic [15:0] atan_q16(input int i);
        logic [15:0] a;
        case (i)
            0:       a = 16'd51472;
            1:       a = 16'd30385;
            2:       a = 16'd16055;
            3:       a = 16'd8150;
            4:       a = 16'd4091;
            5:       a = 16'd2047;
            6:       a = 16'd1024;
            7:       a = 16'd512;
            8:       a = 16'd256;
            9:       a = 16'd128;
            10:      a = 16'd64;
            11:      a = 16'd32;
            12:      a = 16'd16;
            13:      a = 16'd8;
            14:      a = 16'd4;
            default: a = 16'd2;
        endcase
        return a;
    endfunction

    // Anchor height in percent of the box height; zero selects the middle.
    function automatic logic [5:0] anchor_pct(input logic [4:0] cls);
        logic [5:0] p;
        case (cls) inside
            CLS_PCT10_A, CLS_PCT10_B: p = 6'd10;
            CLS_PCT25:                p = 6'd25;
            CLS_PCT05:                p = 6'd5;
            CLS_PCT33:                p = 6'd33;
            default:                  p = 6'd0;
        endcase
        return p;
    endfunction

    // Powers of exp(-1/8), each product truncated to Q.30 in turn.
    function automatic cm_tab_t exp_table();
        cm_tab_t     t;
        logic [63:0] v;
        v = 64'd1 << 30;
        for (int k = 0; k < 128; k++) begin
            t[k] = v[30:0];
            v = (v * EXP_EIGHTH) >> 30;
        end
        return t;
    endfunction

    localparam cm_tab_t CM_TAB = exp_table();

endpackage

@@ rtl/agrs_stats_mem.sv @@
// Statistics table memory with a clearing pass after reset.
// Depends on agrs_pkg.
module agrs_stats_mem
    import agrs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [32:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [32:0]   rd_data,
    output logic          busy
);

    logic [32:0]   mem [0:DEPTH-1];
    logic [32:0]   rd_data_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          busy_reg, busy_next;
    logic          we;
    logic [AW-1:0] wa;
    logic [32:0]   wd;

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        we = busy_reg | wr_en;
        wa = busy_reg ? clr_cnt_reg : wr_addr;
        wd = busy_reg ? 33'd0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

@@ rtl/agrs_cordic.sv @@
// Pipelined CORDIC vectoring: quadrant fold stage plus one stage per iteration.
// Depends on agrs_pkg.
module agrs_cordic
    import agrs_pkg::*;
(
    input  logic                      aclk,
    input  logic [CORDIC_N:0]         en,
    input  logic signed [DELTA_W-1:0] dx,
    input  logic signed [DELTA_W-1:0] dy,
    input  side_t                     side_in,
    output logic signed [ANGLE_W-1:0] angle,
    output side_t                     side_out
);

    logic signed [CORDIC_W-1:0] x_reg [0:CORDIC_N];
    logic signed [CORDIC_W-1:0] y_reg [0:CORDIC_N];
    logic signed [ANGLE_W-1:0]  z_reg [0:CORDIC_N];
    side_t                      s_reg [0:CORDIC_N];

    logic signed [CORDIC_W-1:0] x0, y0;
    logic signed [ANGLE_W-1:0]  z0;
    side_t                      s0;

    always_comb begin
        x0 = CORDIC_W'(dx) <<< 16;
        y0 = CORDIC_W'(dy) <<< 16;
        z0 = '0;
        s0 = side_in;
        s0.zero = (dx == '0) && (dy == '0);
        if (dx < 0) begin
            z0 = (dy >= 0) ? PI_Q16 : -PI_Q16;
            x0 = -x0;
            y0 = -y0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
            s_reg[0] <= s0;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
        localparam logic signed [ANGLE_W-1:0] ATAN = $signed({5'd0, atan_q16(i)});
        logic signed [CORDIC_W-1:0] xs, ys, x_next, y_next;
        logic signed [ANGLE_W-1:0]  z_next;

        always_comb begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] > 0) begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + ATAN;
            end else begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i+1]) begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    // Coincident points have angle zero by definition.
    assign angle    = s_reg[CORDIC_N].zero ? '0 : z_reg[CORDIC_N];
    assign side_out = s_reg[CORDIC_N];

endmodule

@@ rtl/agrs_density.sv @@
// Angle distance, scaling and normal density pipeline (twelve stages).
// Depends on agrs_pkg.
module agrs_density
    import agrs_pkg::*;
(
    input  logic                      aclk,
    input  logic [11:0]               en,
    input  logic signed [ANGLE_W-1:0] angle,
    input  side_t                     side_in,
    output logic [15:0]               score,
    output logic                      no_data
);

    // The no-data flag rides beside the kill flag, one register per stage.
    logic nd_pipe_reg [0:10];

    // Stage 0: quantize angle and take the raw distance.
    logic signed [ANGLE_W-1:0] zr;
    logic signed [16:0] t;
    logic signed [17:0] d0;
    logic [17:0]  dabs_reg;
    logic [15:0]  inv0_reg;
    logic         kill0_reg;

    always_comb begin
        zr = (angle + 21'sd8) >>> 4;
        t  = zr[16:0];
        d0 = 18'(t) - 18'(side_in.ref_ang);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dabs_reg  <= (d0 < 0) ? 18'(-d0) : 18'(d0);
            inv0_reg  <= side_in.inv;
            kill0_reg <= side_in.no_data;
        end
    end

    // Stage 1: fold against a full turn.
    logic signed [18:0] alt, dsel;
    logic [17:0] dfin_reg;
    logic [15:0] inv1_reg;
    logic        kill1_reg;

    always_comb begin
        alt  = TWO_PI_Q12 - $signed({1'b0, dabs_reg});
        dsel = (alt < $signed({1'b0, dabs_reg})) ? alt : $signed({1'b0, dabs_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dfin_reg  <= (dsel < 0) ? 18'(-dsel) : 18'(dsel);
            inv1_reg  <= inv0_reg;
            kill1_reg <= kill0_reg;
        end
    end

    // Stage 2: scale by the inverse spread.
    logic [33:0] u_reg;
    logic        kill2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            u_reg     <= 34'(dfin_reg) * 34'(inv1_reg);
            kill2_reg <= kill1_reg;
        end
    end

    // Stage 3: square; beyond the limit the density is zero.
    logic [45:0] usq;
    logic [33:0] e_reg;
    logic        kill3_reg;

    assign usq = 46'(u_reg[22:0]) * 46'(u_reg[22:0]);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            e_reg     <= usq[44:11];
            kill3_reg <= kill2_reg | (u_reg >= U_LIMIT);
        end
    end

    // Stage 4: coarse factor from the table, r squared.
    logic [53:0] r2p;
    logic [26:0] r4_r_reg;
    logic [23:0] r2_reg;
    logic [30:0] cm4_reg;
    logic        kill4_reg;

    assign r2p = 54'(e_reg[26:0]) * 54'(e_reg[26:0]);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            r4_r_reg  <= e_reg[26:0];
            r2_reg    <= r2p[53:30];
            cm4_reg   <= CM_TAB[e_reg[33:27]];
            kill4_reg <= kill3_reg;
        end
    end

    // Stage 5: r cubed.
    logic [50:0] r3p;
    logic [26:0] r5_r_reg;
    logic [23:0] r5_r2_reg;
    logic [20:0] r3_reg;
    logic [30:0] cm5_reg;
    logic        kill5_reg;

    assign r3p = 51'(r2_reg) * 51'(r4_r_reg);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            r5_r_reg  <= r4_r_reg;
            r5_r2_reg <= r2_reg;
            r3_reg    <= r3p[50:30];
            cm5_reg   <= cm4_reg;
            kill5_reg <= kill4_reg;
        end
    end

    // Stage 6: r to the fourth and r cubed over six.
    logic [47:0] r4p;
    logic [42:0] q6p;
    logic [26:0] r6_r_reg;
    logic [23:0] r6_r2_reg;
    logic [17:0] r4_reg;
    logic [18:0] q6_reg;
    logic [30:0] cm6_reg;
    logic        kill6_reg;

    assign r4p = 48'(r3_reg) * 48'(r5_r_reg);
    assign q6p = 43'(r3_reg) * 43'(RECIP_6);

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            r6_r_reg  <= r5_r_reg;
            r6_r2_reg <= r5_r2_reg;
            r4_reg    <= r4p[47:30];
            q6_reg    <= q6p[42:24];
            cm6_reg   <= cm5_reg;
            kill6_reg <= kill5_reg;
        end
    end

    // Stage 7: r to the fourth over 24, partial Taylor sum.
    logic [36:0] q24p;
    logic [13:0] q24_reg;
    logic [31:0] part_reg;
    logic [30:0] cm7_reg;
    logic        kill7_reg;

    assign q24p = 37'(r4_reg) * 37'(RECIP_24);

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            q24_reg   <= q24p[36:23];
            part_reg  <= Q30_ONE - 32'(r6_r_reg) + 32'(r6_r2_reg >> 1) - 32'(q6_reg);
            cm7_reg   <= cm6_reg;
            kill7_reg <= kill6_reg;
        end
    end

    // Stage 8: finish the Taylor sum.
    logic [30:0] tay_reg;
    logic [30:0] cm8_reg;
    logic        kill8_reg;
    logic [31:0] tay_sum;

    assign tay_sum = part_reg + 32'(q24_reg);

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            tay_reg   <= tay_sum[30:0];
            cm8_reg   <= cm7_reg;
            kill8_reg <= kill7_reg;
        end
    end

    // Stage 9: combine coarse and fine exponential factors.
    logic [61:0] vp;
    logic [30:0] v_reg;
    logic        kill9_reg;

    assign vp = 62'(cm8_reg) * 62'(tay_reg);

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            v_reg     <= vp[60:30];
            kill9_reg <= kill8_reg;
        end
    end

    // Stage 10: apply the peak value of the density.
    logic [59:0] dp;
    logic [29:0] dens_reg;
    logic        kill10_reg;

    assign dp = 60'(v_reg) * 60'(PEAK_Q30);

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            dens_reg   <= dp[59:30];
            kill10_reg <= kill9_reg;
        end
    end

    // Stage 11: round to Q0.16; this is the output register.
    logic [29:0] rnd;
    logic [15:0] score_reg;
    logic        no_data_reg;

    assign rnd = dens_reg + 30'd8192;

    always_ff @(posedge aclk) begin
        if (en[11]) begin
            score_reg   <= kill10_reg ? 16'd0 : rnd[29:14];
            no_data_reg <= nd_pipe_reg[10];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) nd_pipe_reg[0] <= side_in.no_data;
        for (int i = 1; i <= 10; i++) begin
            if (en[i]) nd_pipe_reg[i] <= nd_pipe_reg[i-1];
        end
    end

    assign score   = score_reg;
    assign no_data = no_data_reg;

endmodule

@@ rtl/angle_gaussian_relation_score_core.sv @@
// Angle relation score core: top level, front stages and pipeline control.
// Depends on agrs_pkg, agrs_stats_mem, agrs_cordic and agrs_density.
//
// Usage: the s_ channel carries one item per handshake. A load item
// (s_operation = load) writes s_entry_word into the statistics entry of its
// class pair and gives no result. A query item gives exactly one result on
// the m_ channel: m_score (Q0.16 normal density of the scaled angle
// deviation) and m_no_data, set with a zero score when the entry is not
// marked useful or a class is outside the table.
// Pipeline: a query result passes 31 register stages (2 front, 17 CORDIC,
// 12 density) before it is valid on the m_ ports.
// Throughput: one item per cycle while m_ready is high; every stage has its
// own valid bit and its own enable, so bubbles are squeezed out and s_ready
// stays high while a finished result waits as long as any stage ahead is empty.
// Reset: after aresetn is released the table is cleared one entry a cycle,
// CLASS_COUNT*CLASS_COUNT entries (1024 by default); s_ready stays low during
// that pass. When m_ready is low the result holds on the m_ ports and the
// pipeline fills up behind it, then s_ready drops.
module angle_gaussian_relation_score_core
    import agrs_pkg::*;
#(
    parameter int CLASS_COUNT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [0:0]         s_operation,
    input  logic [4:0]         s_from_class,
    input  logic [4:0]         s_to_class,
    input  logic signed [15:0] s_from_left,
    input  logic signed [15:0] s_from_right,
    input  logic signed [15:0] s_from_top,
    input  logic signed [15:0] s_from_bottom,
    input  logic signed [15:0] s_to_left,
    input  logic signed [15:0] s_to_right,
    input  logic signed [15:0] s_to_top,
    input  logic signed [15:0] s_to_bottom,
    input  logic [32:0]        s_entry_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_score,
    output logic               m_no_data
);

    localparam int DEPTH = CLASS_COUNT * CLASS_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NST   = 2 + CORDIC_N + 1 + 12;

    logic [NST-1:0] vld_reg, vld_next, en;
    logic           acc, clr_busy, class_ok;
    logic [AW-1:0]  addr;
    logic [32:0]    rd_data;

    // Stage i may load when it is empty or its item moves on this cycle.
    assign en[NST-1] = !vld_reg[NST-1] || m_ready;
    for (genvar i = 0; i < NST - 1; i++) begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    assign s_ready = en[0] && !clr_busy;
    assign acc     = s_valid && s_ready;

    always_comb begin
        vld_next[0] = en[0] ? (acc && (op_t'(s_operation) == OP_QUERY)) : vld_reg[0];
        for (int i = 1; i < NST; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign class_ok = (7'(s_from_class) < 7'(CLASS_COUNT)) && (7'(s_to_class) < 7'(CLASS_COUNT));
    assign addr     = AW'(32'(s_from_class) * 32'(CLASS_COUNT) + 32'(s_to_class));

    agrs_stats_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (acc && (op_t'(s_operation) == OP_LOAD) && class_ok),
        .wr_addr (addr),
        .wr_data (s_entry_word),
        .rd_en   (en[0]),
        .rd_addr (addr),
        .rd_data (rd_data),
        .busy    (clr_busy)
    );

    // Stage 0: coordinate sums, anchor selection; table read in parallel.
    logic signed [17:0] dsx_reg;
    logic signed [16:0] fsy_reg;
    logic signed [15:0] tt_reg, tb_reg;
    logic [5:0]         pct_reg;
    logic               ok_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dsx_reg <= (18'(s_to_left) + 18'(s_to_right)) - (18'(s_from_left) + 18'(s_from_right));
            fsy_reg <= 17'(s_from_top) + 17'(s_from_bottom);
            tt_reg  <= s_to_top;
            tb_reg  <= s_to_bottom;
            pct_reg <= anchor_pct(s_to_class);
            ok_reg  <= class_ok;
        end
    end

    // Stage 1: both points scaled by 200 so they stay integers.
    logic signed [16:0]        h, tsum;
    logic signed [24:0]        y200, pct2;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    side_t                     side1_reg, side1;

    always_comb begin
        h    = 17'(tb_reg) - 17'(tt_reg);
        tsum = 17'(tt_reg) + 17'(tb_reg);
        pct2 = $signed({18'd0, pct_reg, 1'b0});
        if (pct_reg == 6'd0) begin
            y200 = 25'(tsum) * 25'sd100;
        end else begin
            y200 = 25'(tt_reg) * 25'sd200 + 25'(h) * pct2;
        end
        side1.no_data = !ok_reg || !rd_data[32];
        side1.zero    = 1'b0;
        side1.ref_ang = $signed(rd_data[31:16]);
        side1.inv     = rd_data[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dx_reg    <= DELTA_W'(dsx_reg) * 27'sd100;
            dy_reg    <= DELTA_W'(y200) - DELTA_W'(fsy_reg) * 27'sd100;
            side1_reg <= side1;
        end
    end

    logic signed [ANGLE_W-1:0] angle;
    side_t                     side_c;

    agrs_cordic u_cordic (
        .aclk     (aclk),
        .en       (en[2 +: CORDIC_N+1]),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .side_in  (side1_reg),
        .angle    (angle),
        .side_out (side_c)
    );

    agrs_density u_density (
        .aclk    (aclk),
        .en      (en[NST-12 +: 12]),
        .angle   (angle),
        .side_in (side_c),
        .score   (m_score),
        .no_data (m_no_data)
    );

    assign m_valid = vld_reg[NST-1];

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("item accepted during table clearing pass");

    a_no_data_zero_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_data) |-> (m_score == 16'd0))
        else $error("no_data result carries a nonzero score");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (op_t'(s_operation) == OP_LOAD)) |=> !vld_reg[0])
        else $error("load item entered the scoring pipeline");

endmodule

@@ tb/angle_gaussian_relation_score_checker.sv @@
// Checker for the angle relation score core: predicts each query result and compares.
// Depends on agrs_pkg; instantiated by angle_gaussian_relation_score_core_test.
`timescale 1ns / 100ps

module angle_gaussian_relation_score_checker
    import agrs_pkg::*;
#(
    parameter int CLASS_COUNT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [0:0]         s_operation,
    input  logic [4:0]         s_from_class,
    input  logic [4:0]         s_to_class,
    input  logic signed [15:0] s_from_left,
    input  logic signed [15:0] s_from_right,
    input  logic signed [15:0] s_from_top,
    input  logic signed [15:0] s_from_bottom,
    input  logic signed [15:0] s_to_left,
    input  logic signed [15:0] s_to_right,
    input  logic signed [15:0] s_to_top,
    input  logic signed [15:0] s_to_bottom,
    input  logic [32:0]        s_entry_word,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [15:0]        m_score,
    input  logic               m_no_data,
    output int                 fail_count,
    output int                 pending_scores,
    output int                 query_count
);

    typedef struct packed {
        logic [15:0] score;
        logic        no_data;
    } score_t;

    logic [32:0] stats_copy [CLASS_COUNT*CLASS_COUNT];
    score_t      score_queue[$];

    localparam longint ATAN_Q16[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint bearing_q12(longint dx, longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 65536;
        y = dy * 65536;
        if (x < 0) begin
            z = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z += ATAN_Q16[i];
            end else begin
                x = x - ys; y = y + xs; z -= ATAN_Q16[i];
            end
        end
        return floor_shift(z + 8, 4);
    endfunction

    function automatic logic [15:0] gauss_q16(longint u);
        longint e, r, r2, r3, r4, tay, v, m;
        if (u >= (64'sd5 << 20)) return 16'd0;
        e = (u * u) >>> 11;
        m = e >>> 27;
        r = e & ((64'sd1 << 27) - 1);
        v = 64'sd1 << 30;
        for (longint k = 0; k < m; k++) v = (v * 64'sd947573834) >>> 30;
        r2 = (r * r) >>> 30;
        r3 = (r2 * r) >>> 30;
        r4 = (r3 * r) >>> 30;
        tay = (64'sd1 << 30) - r + r2 / 2 - r3 / 6 + r4 / 24;
        v = (v * tay) >>> 30;
        v = (v * 64'sd428361012) >>> 30;
        return 16'((v + 8192) >>> 14);
    endfunction

    function automatic score_t predict_score(logic [4:0] fc, logic [4:0] tc,
            longint fl, longint fr, longint ft, longint fb,
            longint tl, longint tr, longint tt, longint tb);
        score_t res;
        logic [32:0] entry;
        longint dx, dy, y200, h, pct, t, d, alt, refa;
        entry = (fc < CLASS_COUNT && tc < CLASS_COUNT) ? stats_copy[fc*CLASS_COUNT+tc] : '0;
        res = '{score: 16'd0, no_data: 1'b1};
        if (!entry[32]) return res;
        h = tb - tt;
        case (tc)
            CLS_PCT10_A, CLS_PCT10_B: pct = 10;
            CLS_PCT25:                pct = 25;
            CLS_PCT05:                pct = 5;
            CLS_PCT33:                pct = 33;
            default:                  pct = 0;
        endcase
        y200 = (pct == 0) ? 100 * (tt + tb) : 200 * tt + 2 * pct * h;
        dx = 100 * ((tl + tr) - (fl + fr));
        dy = y200 - 100 * (ft + fb);
        t = bearing_q12(dx, dy);
        refa = longint'($signed(entry[31:16]));
        d = t - refa;
        if (d < 0) d = -d;
        alt = 25736 - d;
        if (alt < d) d = alt;
        if (d < 0) d = -d;
        res.no_data = 1'b0;
        res.score = gauss_q16(d * longint'(entry[15:0]));
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: error: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        query_count = 0;
        pending_scores = 0;
    end

    always @(posedge aclk) begin
        score_t want;
        if (!aresetn) begin
            foreach (stats_copy[i]) stats_copy[i] = '0;
            score_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_operation == OP_LOAD) begin
                    if (s_from_class < CLASS_COUNT && s_to_class < CLASS_COUNT)
                        stats_copy[s_from_class*CLASS_COUNT+s_to_class] = s_entry_word;
                end else begin
                    query_count++;
                    score_queue.push_back(predict_score(s_from_class, s_to_class,
                        s_from_left, s_from_right, s_from_top, s_from_bottom,
                        s_to_left, s_to_right, s_to_top, s_to_bottom));
                end
            end
            if (m_valid && m_ready) begin
                if (score_queue.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = score_queue.pop_front();
                    if (m_no_data !== want.no_data)
                        report_mismatch($sformatf("no_data %0b, expected %0b",
                            m_no_data, want.no_data));
                    if (m_score !== want.score)
                        report_mismatch($sformatf("score %0d, expected %0d",
                            m_score, want.score));
                end
            end
        end
        pending_scores = score_queue.size();
    end

endmodule

@@ tb/angle_gaussian_relation_score_core_test.sv @@
// Top of the angle relation score testbench: clock, reset, stimulus and verdict.
// Depends on agrs_pkg, the core and angle_gaussian_relation_score_checker.
`timescale 1ns / 100ps

module angle_gaussian_relation_score_core_test;
    import agrs_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [0:0]         s_operation = OP_QUERY;
    logic [4:0]         s_from_class = '0;
    logic [4:0]         s_to_class = '0;
    logic signed [15:0] s_from_left = '0, s_from_right = '0;
    logic signed [15:0] s_from_top = '0, s_from_bottom = '0;
    logic signed [15:0] s_to_left = '0, s_to_right = '0;
    logic signed [15:0] s_to_top = '0, s_to_bottom = '0;
    logic [32:0]        s_entry_word = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_score;
    logic               m_no_data;
    int                 fail_count, pending_scores, query_count;
    bit                 calm_tail = 0;
    bit                 long_hold = 0;
    int                 load_count = 0;

    always #5 aclk = ~aclk;

    angle_gaussian_relation_score_core dut (.*);
    angle_gaussian_relation_score_checker checker_i (.*);

    // Sink side: random stall bursts, one long hold-off on request, none at the tail.
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_hold = 0;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Valid stays high after an accepted item until the next item or an idle gap drops it.
    task automatic send_item(logic op, logic [4:0] fc, logic [4:0] tc,
            logic [15:0] fl, logic [15:0] fr, logic [15:0] ft, logic [15:0] fb,
            logic [15:0] tl, logic [15:0] tr, logic [15:0] tt, logic [15:0] tb,
            logic [32:0] entry);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_from_class <= fc; s_to_class <= tc;
        s_from_left <= fl; s_from_right <= fr; s_from_top <= ft; s_from_bottom <= fb;
        s_to_left <= tl; s_to_right <= tr; s_to_top <= tt; s_to_bottom <= tb;
        s_entry_word <= entry;
        if (op == OP_LOAD) load_count++;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [4:0] rand_class();
        // Mostly classes 2 to 10, which hold the anchor classes, else any class, so loaded entries get hit.
        return $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(2, 10));
    endfunction

    function automatic logic [32:0] rand_entry();
        logic [32:0] e;
        e = {1'b1, 16'($signed($urandom_range(0, 25736)) - 12868),
             16'($urandom_range(0, 2000))};
        case ($urandom_range(0, 9))
            0: e = 33'({$urandom, $urandom});
            1: e[15:0] = 16'($urandom);
            2: e[31:16] = 16'($urandom);
            3: e[15:0] = 16'd0;
            default: ;
        endcase
        return e;
    endfunction

    task automatic random_query();
        send_item(OP_QUERY, rand_class(), rand_class(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), 33'({$urandom, $urandom}));
    endtask

    initial begin
        logic [4:0] anchors[6] = '{CLS_PCT10_A, CLS_PCT10_B, CLS_PCT25, CLS_PCT05,
                                   CLS_PCT33, 5'd0};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: untouched entry, then loads and queries across anchor classes.
        send_item(OP_QUERY, 5'd3, 5'd9, 0, 0, 0, 0, 0, 0, 0, 0, '0);
        foreach (anchors[i])
            send_item(OP_LOAD, 5'd1, anchors[i], 0, 0, 0, 0, 0, 0, 0, 0,
                {1'b1, 16'sd3217, 16'd256});
        send_item(OP_LOAD, 5'd2, 5'd2, 0, 0, 0, 0, 0, 0, 0, 0, {1'b1, 16'h7FFF, 16'd0});
        send_item(OP_LOAD, 5'd31, 5'd31, 0, 0, 0, 0, 0, 0, 0, 0,
            {1'b1, 16'h8000, 16'hFFFF});
        foreach (anchors[i])
            send_item(OP_QUERY, 5'd1, anchors[i], -10, 10, -5, 5, 20, 40, 100, 60, '0);
        send_item(OP_QUERY, 5'd2, 5'd2, 5, 5, 5, 5, 5, 5, 5, 5, '0);
        send_item(OP_QUERY, 5'd2, 5'd2, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, '0);
        send_item(OP_QUERY, 5'd31, 5'd31, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, '0);
        send_item(OP_QUERY, 5'd31, 5'd31, 0, 0, 0, 0, -100, -100, 1, 1, '0);
        send_item(OP_LOAD, 5'd31, 5'd31, 0, 0, 0, 0, 0, 0, 0, 0, '0);
        send_item(OP_QUERY, 5'd31, 5'd31, 0, 0, 0, 0, 1, 1, 1, 1, '0);

        // Random: refill entries now and then, mostly queries.
        for (int n = 0; n < 800; n++) begin
            if (n == 300) long_hold = 1;
            if (n == 500) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                wait (pending_scores == 0);
                repeat (40) @(posedge aclk);
            end
            if (n == 700) calm_tail = 1;
            if ($urandom_range(0, 4) == 0)
                send_item(OP_LOAD, rand_class(), rand_class(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_entry());
            else
                random_query();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_scores == 0);
        repeat (40) @(posedge aclk);
        $display("Run covered %0d queries and %0d table loads, with random stalls on both sides.",
            query_count, load_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", pending_scores);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/agrs_pkg.sv
rtl/agrs_stats_mem.sv
rtl/agrs_cordic.sv
rtl/agrs_density.sv
rtl/angle_gaussian_relation_score_core.sv
tb/angle_gaussian_relation_score_checker.sv
tb/angle_gaussian_relation_score_core_test.sv
